[design/txbsm_pkg.sv]
`timescale 1ns / 1ps

package txbsm_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SEQ_W   = 16;

  localparam logic [TIME_W-1:0]  NEVER_TIME = 32'hFFFF_FFFF;
  localparam logic [INDEX_W-1:0] NO_SLOT    = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_REQ_FREE  = 3'd0,
    OP_MARK_USED = 3'd1,
    OP_MARK_ATT  = 3'd2,
    OP_MARK_DONE = 3'd3,
    OP_MARK_FAIL = 3'd4,
    OP_PICK_OLD  = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_STATE = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef struct packed {
    logic              used;
    logic              waiting;
    logic              attempted;
    logic              processed;
    logic [SEQ_W-1:0]  sequence_no;
    logic [TIME_W-1:0] added_time;
    logic [TIME_W-1:0] sent_time;
  } slot_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] index;
    slot_t              slot;
  } res_t;

endpackage

[design/txbsm_if.sv]
`timescale 1ns / 1ps

interface txbsm_op_if import txbsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [INDEX_W-1:0] slot_index;
  logic [TIME_W-1:0]  now_time;

  modport source (output valid, operation, slot_index, now_time, input ready);
  modport sink   (input valid, operation, slot_index, now_time, output ready);
endinterface

interface txbsm_res_if import txbsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [INDEX_W-1:0] result_index;
  logic               slot_used;
  logic               slot_waiting;
  logic               slot_attempted;
  logic               slot_processed;
  logic [SEQ_W-1:0]   slot_sequence;
  logic [TIME_W-1:0]  slot_added_time;
  logic [TIME_W-1:0]  slot_sent_time;

  modport source (
    output valid, status, result_index, slot_used, slot_waiting, slot_attempted,
           slot_processed, slot_sequence, slot_added_time, slot_sent_time,
    input  ready
  );
  modport sink (
    input  valid, status, result_index, slot_used, slot_waiting, slot_attempted,
           slot_processed, slot_sequence, slot_added_time, slot_sent_time,
    output ready
  );
endinterface

[design/tx_buffer_slot_manager.sv]
`timescale 1ns / 1ps
// channel | dir | words carried
// op_i    | in  | operation, slot_index, now_time
// res_o   | out | status, result_index, slot flags, sequence, added and sent time
//
// mark and read operations go from accept through one slot-store read, one
// read-modify-write and a load into the output register; a bad index skips the first two.
// request free and pick oldest scan the slot store one read per cycle;
// request free stops at the first free slot.
// reset clears every slot at once through per-slot valid flip-flops; no clearing pass.
// one operation at a time; the next is taken while a result waits in res_o, and
// a stalled res_o holds the block in its final state until the word is taken.

module tx_buffer_slot_manager import txbsm_pkg::*; #(
  parameter int unsigned SLOT_COUNT    = 8,
  parameter int unsigned SEQUENCE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  txbsm_op_if.sink    op_i,
  txbsm_res_if.source res_o
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DONE
  } state_e;

  state_e                   state_q, state_d;
  op_e                      op_q, op_d;
  logic [INDEX_W-1:0]       idx_q, idx_d;
  logic [TIME_W-1:0]        now_q, now_d;
  logic [CW-1:0]            iss_q, iss_d;
  logic                     ev_q, ev_d;
  logic [AW-1:0]            ev_idx_q, ev_idx_d;
  logic [TIME_W-1:0]        best_time_q, best_time_d;
  logic [AW-1:0]            best_idx_q, best_idx_d;
  slot_t                    best_slot_q, best_slot_d;
  logic [SEQUENCE_BITS-1:0] seq_q, seq_d;
  res_t                     res_q, res_d;
  res_t                     out_q, out_d;
  logic                     out_vld_q, out_vld_d;
  logic [SLOT_COUNT-1:0]    vld_q, vld_d;
  logic                     rd_vld_q, rd_vld_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;
  slot_t         rd_data_q;
  slot_t         ent;
  logic          accept;

  slot_t mem_q [SLOT_COUNT];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // an entry without its valid bit reads as a cleared slot
  assign ent    = rd_vld_q ? rd_data_q : slot_t'('0);
  assign accept = op_i.valid && op_i.ready;

  always_comb begin
    slot_t         nw;
    logic          cand;
    logic [TIME_W-1:0] pick_time;
    logic [AW-1:0] pick_idx;
    slot_t         pick_slot;

    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    now_d       = now_q;
    iss_d       = iss_q;
    ev_d        = 1'b0;
    ev_idx_d    = ev_idx_q;
    best_time_d = best_time_q;
    best_idx_d  = best_idx_q;
    best_slot_d = best_slot_q;
    seq_d       = seq_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    vld_d       = vld_q;
    rd_en       = 1'b0;
    rd_addr     = iss_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_q[AW-1:0];
    wr_data     = ent;
    nw          = ent;
    cand        = ent.waiting && !ent.attempted && (ent.added_time < best_time_q);
    pick_time   = cand ? ent.added_time : best_time_q;
    pick_idx    = cand ? ev_idx_q : best_idx_q;
    pick_slot   = cand ? ent : best_slot_q;

    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (op_i.valid) begin
          op_d        = op_e'(op_i.operation);
          idx_d       = op_i.slot_index;
          now_d       = op_i.now_time;
          iss_d       = '0;
          best_time_d = NEVER_TIME;
          best_idx_d  = '0;
          best_slot_d = '0;
          case (op_e'(op_i.operation))
            OP_REQ_FREE, OP_PICK_OLD: begin
              state_d = S_SCAN;
            end
            OP_MARK_USED, OP_MARK_ATT, OP_MARK_DONE, OP_MARK_FAIL, OP_READ: begin
              if ({1'b0, op_i.slot_index} >= (INDEX_W+1)'(SLOT_COUNT)) begin
                res_d   = '{status: ST_RANGE, index: op_i.slot_index, slot: '0};
                state_d = S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = op_i.slot_index[AW-1:0];
                state_d = S_EXEC;
              end
            end
            default: begin
              res_d   = '{status: ST_NONE, index: NO_SLOT, slot: '0};
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // reads issue one slot ahead of the evaluation
        rd_en    = (iss_q < CW'(SLOT_COUNT));
        ev_d     = rd_en;
        ev_idx_d = iss_q[AW-1:0];
        if (rd_en) begin
          iss_d = iss_q + CW'(1);
        end
        if (ev_q) begin
          if (op_q == OP_REQ_FREE) begin
            if (!ent.used) begin
              vld_d[ev_idx_q] = 1'b0;
              res_d   = '{status: ST_OK, index: INDEX_W'(ev_idx_q), slot: '0};
              ev_d    = 1'b0;
              state_d = S_DONE;
            end else if (ev_idx_q == AW'(SLOT_COUNT - 1)) begin
              res_d   = '{status: ST_NONE, index: NO_SLOT, slot: '0};
              ev_d    = 1'b0;
              state_d = S_DONE;
            end
          end else begin
            best_time_d = pick_time;
            best_idx_d  = pick_idx;
            best_slot_d = pick_slot;
            if (ev_idx_q == AW'(SLOT_COUNT - 1)) begin
              // a pick time below all ones means some slot qualified
              if (pick_time != NEVER_TIME) begin
                res_d = '{status: ST_OK, index: INDEX_W'(pick_idx), slot: pick_slot};
              end else begin
                res_d = '{status: ST_NONE, index: NO_SLOT, slot: '0};
              end
              ev_d    = 1'b0;
              state_d = S_DONE;
            end
          end
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_READ: begin
            res_d = '{status: ST_OK, index: idx_q, slot: ent};
          end
          OP_MARK_USED: begin
            if (ent.used) begin
              res_d = '{status: ST_STATE, index: idx_q, slot: ent};
            end else begin
              nw.used        = 1'b1;
              nw.waiting     = 1'b1;
              nw.attempted   = 1'b0;
              nw.processed   = 1'b0;
              nw.sequence_no = SEQ_W'(seq_q);
              nw.added_time  = now_q;
              wr_en          = 1'b1;
              wr_data        = nw;
              vld_d[idx_q[AW-1:0]] = 1'b1;
              seq_d          = seq_q + SEQUENCE_BITS'(1);
              res_d          = '{status: ST_OK, index: idx_q, slot: nw};
            end
          end
          OP_MARK_ATT, OP_MARK_DONE, OP_MARK_FAIL: begin
            if (!ent.used) begin
              res_d = '{status: ST_STATE, index: idx_q, slot: ent};
            end else begin
              if (op_q == OP_MARK_ATT) begin
                nw.waiting   = 1'b0;
                nw.attempted = 1'b1;
              end else if (op_q == OP_MARK_DONE) begin
                nw.processed = 1'b1;
                nw.sent_time = now_q;
                nw.used      = 1'b0;
              end else begin
                nw.waiting   = 1'b0;
                nw.processed = 1'b1;
                nw.used      = 1'b0;
              end
              wr_en   = 1'b1;
              wr_data = nw;
              vld_d[idx_q[AW-1:0]] = 1'b1;
              res_d   = '{status: ST_OK, index: idx_q, slot: nw};
            end
          end
          default: begin
            res_d = '{status: ST_NONE, index: NO_SLOT, slot: '0};
          end
        endcase
      end

      S_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_vld_d = rd_en ? vld_q[rd_addr] : rd_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_REQ_FREE;
      idx_q       <= '0;
      now_q       <= '0;
      iss_q       <= '0;
      ev_q        <= 1'b0;
      ev_idx_q    <= '0;
      best_time_q <= NEVER_TIME;
      best_idx_q  <= '0;
      best_slot_q <= '0;
      seq_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_vld_q   <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      now_q       <= now_d;
      iss_q       <= iss_d;
      ev_q        <= ev_d;
      ev_idx_q    <= ev_idx_d;
      best_time_q <= best_time_d;
      best_idx_q  <= best_idx_d;
      best_slot_q <= best_slot_d;
      seq_q       <= seq_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_vld_q   <= out_vld_d;
      vld_q       <= vld_d;
      rd_vld_q    <= rd_vld_d;
    end
  end

  assign op_i.ready            = (state_q == S_IDLE);
  assign res_o.valid           = out_vld_q;
  assign res_o.status          = out_q.status;
  assign res_o.result_index    = out_q.index;
  assign res_o.slot_used       = out_q.slot.used;
  assign res_o.slot_waiting    = out_q.slot.waiting;
  assign res_o.slot_attempted  = out_q.slot.attempted;
  assign res_o.slot_processed  = out_q.slot.processed;
  assign res_o.slot_sequence   = out_q.slot.sequence_no;
  assign res_o.slot_added_time = out_q.slot.added_time;
  assign res_o.slot_sent_time  = out_q.slot.sent_time;

`ifndef ASSERT_OFF
  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_EXEC))
    else $error("slot store written outside read-modify-write");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted word did not start an operation");

  a_seq_only_on_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != $past(seq_q)) |-> $past(wr_en && (op_q == OP_MARK_USED)))
    else $error("sequence counter moved without a mark used");

  a_eval_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q |-> (state_q == S_SCAN))
    else $error("scan evaluation outside scan");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !$past(out_vld_q)) |-> $past(state_q == S_DONE))
    else $error("result word loaded outside final state");
`endif

endmodule

[verif/tx_buffer_slot_manager_tb.sv]
`timescale 1ns / 1ps

module tx_buffer_slot_manager_tb;
  import txbsm_pkg::*;

  localparam int unsigned SLOT_COUNT   = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int unsigned ITEM_TARGET  = 1275;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] slot_index;
    logic [TIME_W-1:0]  now_time;
  } op_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  txbsm_op_if  op_if ();
  txbsm_res_if res_if ();

  tx_buffer_slot_manager i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_if),
    .res_o  (res_if)
  );

  logic     op_valid = 1'b0;
  op_word_t op_word  = '0;
  logic     op_taken = 1'b0;
  logic     res_ready = 1'b0;

  assign op_if.valid      = op_valid;
  assign op_if.operation  = op_word.operation;
  assign op_if.slot_index = op_word.slot_index;
  assign op_if.now_time   = op_word.now_time;
  assign res_if.ready     = res_ready;

  op_word_t pending_ops[$];
  res_t     expected_res[$];
  int       error_count = 0;
  int       item_count  = 0;

  // shadow of the slot pool
  slot_t             slot_store [SLOT_COUNT];
  logic [SEQ_W-1:0]  seq_ctr;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic res_t apply_slot_op(input op_word_t w);
    res_t             r;
    int               lowest_free;
    int               oldest;
    logic [TIME_W-1:0] oldest_time;
    int               idx;
    r           = '0;
    r.status    = ST_NONE;
    r.index     = NO_SLOT;
    idx         = w.slot_index;
    lowest_free = -1;
    oldest      = -1;
    oldest_time = NEVER_TIME;
    case (w.operation)
      OP_REQ_FREE: begin
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
          if (!slot_store[s].used) lowest_free = s;
        end
        if (lowest_free >= 0) begin
          slot_store[lowest_free] = '0;
          r.status = ST_OK;
          r.index  = INDEX_W'(lowest_free);
          r.slot   = slot_store[lowest_free];
        end
      end
      OP_PICK_OLD: begin
        // strict less-than keeps ties on the lowest index and skips the never time
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (slot_store[s].waiting && !slot_store[s].attempted &&
              slot_store[s].added_time < oldest_time) begin
            oldest_time = slot_store[s].added_time;
            oldest      = s;
          end
        end
        if (oldest >= 0) begin
          r.status = ST_OK;
          r.index  = INDEX_W'(oldest);
          r.slot   = slot_store[oldest];
        end
      end
      OP_UNUSED: begin
      end
      default: begin
        r.index = w.slot_index;
        if (idx >= SLOT_COUNT) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_OK;
          case (w.operation)
            OP_MARK_USED: begin
              if (slot_store[idx].used) begin
                r.status = ST_STATE;
              end else begin
                slot_store[idx].sequence_no = seq_ctr;
                seq_ctr                     = seq_ctr + 1'b1;
                slot_store[idx].added_time  = w.now_time;
                slot_store[idx].used        = 1'b1;
                slot_store[idx].waiting     = 1'b1;
                slot_store[idx].attempted   = 1'b0;
                slot_store[idx].processed   = 1'b0;
              end
            end
            OP_MARK_ATT, OP_MARK_DONE, OP_MARK_FAIL: begin
              if (!slot_store[idx].used) begin
                r.status = ST_STATE;
              end else if (w.operation == OP_MARK_ATT) begin
                slot_store[idx].waiting   = 1'b0;
                slot_store[idx].attempted = 1'b1;
              end else if (w.operation == OP_MARK_DONE) begin
                slot_store[idx].processed = 1'b1;
                slot_store[idx].sent_time = w.now_time;
                slot_store[idx].used      = 1'b0;
              end else begin
                slot_store[idx].waiting   = 1'b0;
                slot_store[idx].processed = 1'b1;
                slot_store[idx].used      = 1'b0;
              end
            end
            default: begin
            end
          endcase
          r.slot = slot_store[idx];
        end
      end
    endcase
    return r;
  endfunction

  task automatic push_op(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                         input logic [TIME_W-1:0] now);
    op_word_t w;
    w.operation  = op;
    w.slot_index = idx;
    w.now_time   = now;
    pending_ops.push_back(w);
    if (op != OP_UNUSED) item_count++;
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return NEVER_TIME;
      1, 2:    return $urandom_range(0, 3);
      3:       return NEVER_TIME - $urandom_range(1, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // sender: bursts of words with random gaps between them
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (op_taken || !op_valid)) begin
      if (gap_left > 0) begin
        gap_left--;
        op_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op_word  <= pending_ops.pop_front();
        op_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        op_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, reloaded now and then, sometimes all ready
  logic [7:0] stall_pat = 8'hFF;
  int         pat_age   = 0;

  always @(negedge clk_i) begin
    if (pat_age == 0) begin
      pat_age   = 32;
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    pat_age--;
    stall_pat = {stall_pat[0], stall_pat[7:1]};
    res_ready <= stall_pat[0];
  end

  always @(posedge clk_i) begin
    if (rst_ni && op_valid && op_if.ready) begin
      expected_res.push_back(apply_slot_op(op_word));
    end
    op_taken <= rst_ni && op_valid && op_if.ready;
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_ready) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result word: status %0d index %0d",
               res_if.status, res_if.result_index);
        error_count++;
      end else begin
        want = expected_res.pop_front();
        check_field("status",          64'(want.status),           64'(res_if.status));
        check_field("result_index",    64'(want.index),            64'(res_if.result_index));
        check_field("slot_used",       64'(want.slot.used),        64'(res_if.slot_used));
        check_field("slot_waiting",    64'(want.slot.waiting),     64'(res_if.slot_waiting));
        check_field("slot_attempted",  64'(want.slot.attempted),
                    64'(res_if.slot_attempted));
        check_field("slot_processed",  64'(want.slot.processed),
                    64'(res_if.slot_processed));
        check_field("slot_sequence",   64'(want.slot.sequence_no),
                    64'(res_if.slot_sequence));
        check_field("slot_added_time", 64'(want.slot.added_time),
                    64'(res_if.slot_added_time));
        check_field("slot_sent_time",  64'(want.slot.sent_time),
                    64'(res_if.slot_sent_time));
      end
    end
  end

  initial begin
    int unsigned s;
    for (int i = 0; i < SLOT_COUNT; i++) slot_store[i] = '0;
    seq_ctr = '0;

    // directed: empty pool, bad codes and indexes, never time, ties, full pool
    push_op(OP_READ,      8'd0,   32'd0);
    push_op(OP_PICK_OLD,  8'd0,   32'd0);
    push_op(OP_UNUSED,    8'd3,   32'd5);
    push_op(OP_MARK_ATT,  8'd3,   32'd1);
    push_op(OP_MARK_DONE, 8'd3,   32'd2);
    push_op(OP_MARK_FAIL, 8'd3,   32'd3);
    push_op(OP_READ,      8'd8,   32'd0);
    push_op(OP_MARK_USED, 8'd255, 32'd7);
    push_op(OP_REQ_FREE,  8'd0,   32'd0);
    push_op(OP_MARK_USED, 8'd0,   NEVER_TIME);
    push_op(OP_PICK_OLD,  8'd0,   32'd0);
    push_op(OP_MARK_USED, 8'd0,   32'd9);
    push_op(OP_MARK_USED, 8'd1,   32'd0);
    push_op(OP_MARK_USED, 8'd2,   32'd0);
    push_op(OP_PICK_OLD,  8'd0,   32'd0);
    push_op(OP_MARK_ATT,  8'd1,   32'd0);
    push_op(OP_PICK_OLD,  8'd0,   32'd0);
    push_op(OP_MARK_DONE, 8'd2,   NEVER_TIME);
    push_op(OP_MARK_FAIL, 8'd0,   32'd0);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i != 1) push_op(OP_MARK_USED, INDEX_W'(i), 32'h8000_0000 + TIME_W'(i));
    end
    push_op(OP_REQ_FREE,  8'd0,   32'd0);

    // random: mostly slot lifecycles, the rest noise
    while (item_count < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) begin
        s = $urandom_range(0, SLOT_COUNT - 1);
        if ($urandom_range(0, 1)) push_op(OP_REQ_FREE, INDEX_W'($urandom), $urandom);
        push_op(OP_MARK_USED, INDEX_W'(s), pick_time());
        if ($urandom_range(0, 1)) push_op(OP_PICK_OLD, INDEX_W'($urandom), $urandom);
        case ($urandom_range(0, 5))
          0: begin
            push_op(OP_MARK_ATT, INDEX_W'(s), $urandom);
            push_op(OP_MARK_DONE, INDEX_W'(s), pick_time());
          end
          1: begin
            push_op(OP_MARK_ATT, INDEX_W'(s), $urandom);
            push_op(OP_MARK_FAIL, INDEX_W'(s), $urandom);
          end
          2: push_op(OP_MARK_FAIL, INDEX_W'(s), $urandom);
          3: push_op(OP_MARK_DONE, INDEX_W'(s), pick_time());
          4: push_op(OP_MARK_ATT, INDEX_W'(s), $urandom);
          default: begin
          end
        endcase
        if ($urandom_range(0, 2) == 0) push_op(OP_READ, INDEX_W'(s), $urandom);
      end else begin
        push_op(OP_W'($urandom_range(0, 7)),
                INDEX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, SLOT_COUNT - 1)),
                pick_time());
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || op_valid) @(posedge clk_i);
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[tx_buffer_slot_manager.f]
design/txbsm_pkg.sv
design/txbsm_if.sv
design/tx_buffer_slot_manager.sv
verif/tx_buffer_slot_manager_tb.sv
